/* rtl/core/lsb_stego_extractor_macros.svh */
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Shared concurrent assertion wrappers for the extractor checker.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LSBSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LSBSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lsbse_pkg.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Types and codes shared by the extractor front, queue, back and checker.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  // hiding schemes (mode register)
  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;
  // unused code, parsed as one-bit LSB
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_ENCRYPTED = 2'd1;
  localparam logic [1:0] REG_CAPACITY  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EXT   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int unsigned SIZE_BITS = 32;

  // classified carrier byte
  typedef struct packed {
    logic       restart;  // image start
    logic       wide;     // four bits per byte
    logic       invert;   // pattern inversion scheme
    logic [1:0] sel;      // inversion flag select
    logic [3:0] bits;     // low nibble (wide) or lsb in bit 0
  } item_t;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_FLAGS = 6'b000010,
    PH_SIZE  = 6'b000100,
    PH_BODY  = 6'b001000,
    PH_EXT   = 6'b010000,
    PH_IDLE  = 6'b100000
  } phase_t;

endpackage

/* rtl/core/lsbse_front.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor front
// Registers incoming pixel bytes and classifies them by hiding scheme.
// ----------------------------------------------------------------------------
module lsbse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                image_start,
  input  logic [7:0]          carrier_byte,
  input  logic [1:0]          mode,
  output logic                push_valid,
  input  logic                push_ready,
  output lsbse_pkg::item_t    push_item
);

  logic             fr_valid;
  logic             fr_valid_next;
  lsbse_pkg::item_t fr_item;
  lsbse_pkg::item_t item_next;
  logic             take;

  assign in_ready = !fr_valid || push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    item_next.restart = image_start;
    item_next.wide    = (mode == lsbse_pkg::MODE_LSB4);
    item_next.invert  = (mode == lsbse_pkg::MODE_LSBI);
    item_next.sel     = carrier_byte[2:1];
    item_next.bits    = (mode == lsbse_pkg::MODE_LSB4) ? carrier_byte[3:0]
                                                       : {3'b000, carrier_byte[0]};
  end

  assign fr_valid_next = take || (fr_valid && !push_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item <= item_next;
    end
  end

  assign push_valid = fr_valid;
  assign push_item  = fr_item;

endmodule

/* rtl/core/lsbse_queue.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module lsbse_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  lsbse_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop,
  output lsbse_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lsbse_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/core/lsbse_back.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor back
// Message parser: flags, size, body and extension phases, result register.
// ----------------------------------------------------------------------------
module lsbse_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  lsbse_pkg::item_t q_item,
  output logic             q_pop,
  input  logic             encrypted_payload,
  input  logic [31:0]      image_capacity,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_byte,
  output logic [1:0]       kind,
  output logic             last_of_message
);

  lsbse_pkg::phase_t phase, phase_next;
  logic [3:0]        invert_flags, invert_flags_next;
  logic [31:0]       payload_size, payload_size_next;
  logic [5:0]        carrier_count, carrier_count_next;
  logic [7:0]        byte_accumulator, byte_accumulator_next;
  logic [31:0]       body_remaining, body_remaining_next;

  logic [5:0]  step;
  logic [5:0]  count_sum;
  logic [3:0]  val;
  logic [31:0] size_shift;
  logic [31:0] size_limit;
  logic [7:0]  acc_shift;
  logic [31:0] remaining_dec;
  logic        res_valid;
  logic [7:0]  res_data;
  logic [1:0]  res_kind;
  logic        res_last;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next            = phase;
    invert_flags_next     = invert_flags;
    payload_size_next     = payload_size;
    carrier_count_next    = carrier_count;
    byte_accumulator_next = byte_accumulator;
    body_remaining_next   = body_remaining;
    res_valid = 1'b0;
    res_data  = 8'h00;
    res_kind  = lsbse_pkg::KIND_BODY;
    res_last  = 1'b0;

    // a restart (or first byte after reset) opens a new message
    if (q_item.restart || phase == lsbse_pkg::PH_START) begin
      invert_flags_next     = 4'h0;
      payload_size_next     = 32'h0;
      carrier_count_next    = 6'd0;
      byte_accumulator_next = 8'h00;
      body_remaining_next   = 32'h0;
      phase_next = q_item.invert ? lsbse_pkg::PH_FLAGS : lsbse_pkg::PH_SIZE;
    end

    step      = q_item.wide ? 6'd4 : 6'd1;
    count_sum = carrier_count_next + step;
    val       = q_item.invert
                ? {3'b000, q_item.bits[0] ^ invert_flags_next[q_item.sel]}
                : q_item.bits;
    size_shift = q_item.wide ? {payload_size_next[27:0], val}
                             : {payload_size_next[30:0], val[0]};
    // size * 2 (or * 8) > capacity  <=>  size > capacity >> 1 (or >> 3)
    size_limit = q_item.wide ? {1'b0, image_capacity[31:1]}
                             : {3'b000, image_capacity[31:3]};
    acc_shift  = q_item.wide ? {byte_accumulator_next[3:0], val}
                             : {byte_accumulator_next[6:0], val[0]};
    remaining_dec = body_remaining_next - 32'd1;

    unique case (phase_next)
      lsbse_pkg::PH_FLAGS: begin
        invert_flags_next = invert_flags_next
                          | (4'(q_item.bits[0]) << carrier_count_next[1:0]);
        carrier_count_next = carrier_count_next + 6'd1;
        if (carrier_count_next >= 6'd4) begin
          carrier_count_next = 6'd0;
          phase_next = lsbse_pkg::PH_SIZE;
        end
      end
      lsbse_pkg::PH_SIZE: begin
        payload_size_next  = size_shift;
        carrier_count_next = count_sum;
        if (count_sum >= 6'(lsbse_pkg::SIZE_BITS)) begin
          carrier_count_next = 6'd0;
          if (size_shift > size_limit) begin
            phase_next = lsbse_pkg::PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = lsbse_pkg::KIND_ERROR;
            res_last   = 1'b1;
          end else begin
            body_remaining_next = size_shift;
            if (size_shift == 32'h0) begin
              phase_next = encrypted_payload ? lsbse_pkg::PH_IDLE : lsbse_pkg::PH_EXT;
            end else begin
              phase_next = lsbse_pkg::PH_BODY;
            end
          end
        end
      end
      lsbse_pkg::PH_BODY, lsbse_pkg::PH_EXT: begin
        if (count_sum < 6'd8) begin
          byte_accumulator_next = acc_shift;
          carrier_count_next    = count_sum;
        end else begin
          byte_accumulator_next = 8'h00;
          carrier_count_next    = 6'd0;
          res_valid = 1'b1;
          res_data  = acc_shift;
          if (phase_next == lsbse_pkg::PH_BODY) begin
            body_remaining_next = remaining_dec;
            if (remaining_dec == 32'h0) begin
              res_last   = encrypted_payload;
              phase_next = encrypted_payload ? lsbse_pkg::PH_IDLE : lsbse_pkg::PH_EXT;
            end
          end else begin
            res_kind = lsbse_pkg::KIND_EXT;
            if (acc_shift == 8'h00) begin
              res_last   = 1'b1;
              phase_next = lsbse_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
        // waiting for the next image start: byte dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lsbse_pkg::PH_START;
      invert_flags     <= 4'h0;
      payload_size     <= 32'h0;
      carrier_count    <= 6'd0;
      byte_accumulator <= 8'h00;
      body_remaining   <= 32'h0;
      out_valid        <= 1'b0;
    end else begin
      if (q_pop) begin
        phase            <= phase_next;
        invert_flags     <= invert_flags_next;
        payload_size     <= payload_size_next;
        carrier_count    <= carrier_count_next;
        byte_accumulator <= byte_accumulator_next;
        body_remaining   <= body_remaining_next;
      end
      if (!out_valid || out_ready) begin
        out_valid <= q_pop && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      data_byte       <= res_data;
      kind            <= res_kind;
      last_of_message <= res_last;
    end
  end

endmodule

/* rtl/core/lsb_stego_extractor.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor
// Recovers a hidden message (size, body, extension) from carrier pixel bytes.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, image_start, carrier_byte | to block
//  out     | out_valid/out_ready, data_byte, kind, last_of_message | from block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | to block
//
//  One pixel byte per cycle sustained unless the output stalls; the parser
//  retires one queued byte each cycle. A result is registered after the queue.
//  Reset clears all control state at once; there is no clearing pass.
//  A stalled output holds the parser only when the result register is full;
//  the front and the queue keep taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module lsb_stego_extractor #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        image_start,
  input  logic [7:0]  carrier_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [1:0]  kind,
  output logic        last_of_message,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]       mode;
  logic             encrypted_payload;
  logic [31:0]      image_capacity;

  logic             push_valid;
  logic             push_ready;
  lsbse_pkg::item_t push_item;
  logic             q_valid;
  logic             q_pop;
  lsbse_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= lsbse_pkg::MODE_LSB1;
      encrypted_payload <= 1'b0;
      image_capacity    <= 32'h0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsbse_pkg::REG_MODE:      mode              <= cfg_data[1:0];
        lsbse_pkg::REG_ENCRYPTED: encrypted_payload <= cfg_data[0];
        lsbse_pkg::REG_CAPACITY:  image_capacity    <= cfg_data;
        default: begin
          // unmapped index: write ignored
        end
      endcase
    end
  end

  lsbse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .image_start  (image_start),
    .carrier_byte (carrier_byte),
    .mode         (mode),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  lsbse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  lsbse_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .encrypted_payload (encrypted_payload),
    .image_capacity    (image_capacity),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .data_byte         (data_byte),
    .kind              (kind),
    .last_of_message   (last_of_message)
  );

endmodule

/* rtl/core/lsbse_checker.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lsb_stego_extractor_macros.svh"

module lsbse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic [1:0] kind,
  input logic       last_of_message
);

  // stalled result transaction holds
  `LSBSE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(kind) && $stable(last_of_message), "result changed while stalled")

  // capacity error is a zero byte that ends the message
  `LSBSE_ASSERT(a_err_shape, out_valid && kind == lsbse_pkg::KIND_ERROR |-> data_byte == 8'h00 && last_of_message, "malformed error result")

  // extension ends exactly at its zero byte
  `LSBSE_ASSERT(a_ext_last, out_valid && kind == lsbse_pkg::KIND_EXT |-> last_of_message == (data_byte == 8'h00), "extension end mismatch")

  // no result right after reset
  `LSBSE_ASSERT_ALWAYS(a_rst_quiet, rst |=> !out_valid, "result valid after reset")

endmodule

bind lsb_stego_extractor lsbse_checker u_lsbse_checker (.*);

/* tb/lsb_stego_extractor_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSB stego extractor testbench
// Streams carrier bytes that hide well-formed messages (size, body, extension)
// in every scheme, mixed with restarts, cut-off messages and stray bytes, and
// checks each recovered byte against a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_test;

  localparam int unsigned PHASE_ITEMS   = 255;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] code;
    logic       last;
  } recovered_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       typed;  // exp holds a hand-written result
    recovered_t exp;
  } stim_item_t;

  // four-bit scheme, capacity 0: empty body with a two-byte extension, a stray
  // byte, then a restart in mid-size and a size of one that overflows capacity
  localparam stim_item_t DIRECTED [24] = '{
    {1'b1, 8'hF0, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'hA0, 1'b0, 11'h000},
    {1'b0, 8'h50, 1'b0, 11'h000},
    {1'b0, 8'hF0, 1'b0, 11'h000},
    {1'b0, 8'h30, 1'b0, 11'h000},
    {1'b0, 8'hC0, 1'b0, 11'h000},
    {1'b0, 8'h60, 1'b0, 11'h000},
    {1'b0, 8'h0F, 1'b0, 11'h000},
    {1'b0, 8'hFF, 1'b1, 8'hFF, lsbse_pkg::KIND_EXT, 1'b0},
    {1'b0, 8'h80, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b1, 8'h00, lsbse_pkg::KIND_EXT, 1'b1},
    {1'b0, 8'hFF, 1'b0, 11'h000},
    {1'b1, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'hFF, 1'b0, 11'h000},
    {1'b1, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'h00, 1'b0, 11'h000},
    {1'b0, 8'hF1, 1'b1, 8'h00, lsbse_pkg::KIND_ERROR, 1'b1},
    {1'b0, 8'h5A, 1'b0, 11'h000}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        image_start;
  logic [7:0]  carrier_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  data_byte;
  logic [1:0]  kind;
  logic        last_of_message;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // register shadows
  logic [1:0]  reg_mode      = lsbse_pkg::MODE_LSB1;
  logic        reg_encrypted = 1'b0;
  logic [31:0] reg_capacity  = '0;

  // predictor state
  lsbse_pkg::phase_t st_phase = lsbse_pkg::PH_START;
  logic [3:0]  st_flags     = '0;
  logic [31:0] st_size      = '0;
  logic [5:0]  st_count     = '0;
  logic [7:0]  st_acc       = '0;
  logic [31:0] st_remaining = '0;

  stim_item_t  carrier_q[$];
  stim_item_t  draft[$];
  stim_item_t  offered;
  recovered_t  pending_bytes[$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned msg_items     = 0;
  int unsigned stalled       = 0;
  bit          hold_req      = 1'b0;
  bit          hold_served   = 1'b0;

  lsb_stego_extractor DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .image_start     (image_start),
    .carrier_byte    (carrier_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_byte       (data_byte),
    .kind            (kind),
    .last_of_message (last_of_message),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t MISMATCH %s", $realtime, what);
    end
    mismatches++;
  endtask

  // one carrier byte through the parser; returns 1 when it yields a result
  function automatic bit recover_step(input logic start, input logic [7:0] b,
                                      output recovered_t r);
    logic [3:0]  v;
    int unsigned w;
    logic [34:0] need;
    r = '0;
    if (start || st_phase == lsbse_pkg::PH_START) begin
      st_flags     = '0;
      st_size      = '0;
      st_count     = '0;
      st_acc       = '0;
      st_remaining = '0;
      st_phase     = (reg_mode == lsbse_pkg::MODE_LSBI) ? lsbse_pkg::PH_FLAGS
                                                        : lsbse_pkg::PH_SIZE;
    end
    if (reg_mode == lsbse_pkg::MODE_LSB4) begin
      w = 4;
      v = b[3:0];
    end else if (reg_mode == lsbse_pkg::MODE_LSBI) begin
      w = 1;
      v = {3'b000, b[0] ^ st_flags[b[2:1]]};
    end else begin
      w = 1;
      v = {3'b000, b[0]};
    end
    case (st_phase)
      lsbse_pkg::PH_FLAGS: begin
        st_flags[st_count[1:0]] = st_flags[st_count[1:0]] | b[0];
        st_count = st_count + 6'd1;
        if (st_count >= 6'd4) begin
          st_count = '0;
          st_phase = lsbse_pkg::PH_SIZE;
        end
        return 1'b0;
      end
      lsbse_pkg::PH_SIZE: begin
        st_size  = (st_size << w) | {28'h0, v};
        st_count = st_count + 6'(w);
        if (st_count >= 6'd32) begin
          // no wrap: 35 bits hold size * 8
          need     = {3'b000, st_size} << ((reg_mode == lsbse_pkg::MODE_LSB4) ? 1 : 3);
          st_count = '0;
          if (need > {3'b000, reg_capacity}) begin
            st_phase = lsbse_pkg::PH_IDLE;
            r = {8'h00, lsbse_pkg::KIND_ERROR, 1'b1};
            return 1'b1;
          end
          st_remaining = st_size;
          if (st_remaining == 0) begin
            st_phase = reg_encrypted ? lsbse_pkg::PH_IDLE : lsbse_pkg::PH_EXT;
          end else begin
            st_phase = lsbse_pkg::PH_BODY;
          end
        end
        return 1'b0;
      end
      lsbse_pkg::PH_BODY, lsbse_pkg::PH_EXT: begin
        st_acc   = (st_acc << w) | {4'h0, v};
        st_count = st_count + 6'(w);
        if (st_count < 6'd8) begin
          return 1'b0;
        end
        st_count = '0;
        r.value  = st_acc;
        st_acc   = '0;
        if (st_phase == lsbse_pkg::PH_BODY) begin
          r.code       = lsbse_pkg::KIND_BODY;
          st_remaining = st_remaining - 32'd1;
          if (st_remaining == 0) begin
            r.last   = reg_encrypted;
            st_phase = reg_encrypted ? lsbse_pkg::PH_IDLE : lsbse_pkg::PH_EXT;
          end
        end else begin
          r.code = lsbse_pkg::KIND_EXT;
          r.last = (r.value == 8'h00);
          if (r.value == 8'h00) begin
            st_phase = lsbse_pkg::PH_IDLE;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    recovered_t seen;
    recovered_t want;
    recovered_t predicted;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = {data_byte, kind, last_of_message};
        results_seen++;
        if (pending_bytes.size() == 0) begin
          flag_mismatch($sformatf("result %0d (%h/%0d/%0d) with nothing pending",
                                  results_seen, seen.value, seen.code, seen.last));
        end else begin
          want = pending_bytes.pop_front();
          if (seen.value !== want.value) begin
            flag_mismatch($sformatf("result %0d data_byte %h, want %h",
                                    results_seen, seen.value, want.value));
          end
          if (seen.code !== want.code) begin
            flag_mismatch($sformatf("result %0d kind %0d, want %0d",
                                    results_seen, seen.code, want.code));
          end
          if (seen.last !== want.last) begin
            flag_mismatch($sformatf("result %0d last_of_message %0d, want %0d",
                                    results_seen, seen.last, want.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (recover_step(image_start, carrier_byte, predicted) && !offered.typed) begin
          pending_bytes.push_back(predicted);
        end
        if (offered.typed) begin
          pending_bytes.push_back(offered.exp);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // sender: bursts of random length, random gaps between them
  initial begin : sender
    int unsigned burst_left;
    int unsigned gap_left;
    in_valid     = 1'b0;
    image_start  = 1'b0;
    carrier_byte = 8'h00;
    offered      = '0;
    burst_left   = 1;
    gap_left     = 0;
    forever begin
      @(negedge clk);
      if (gap_left > 0 || carrier_q.size() == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end
        in_valid <= 1'b0;
      end else begin
        offered = carrier_q.pop_front();
        in_valid     <= 1'b1;
        image_start  <= offered.start;
        carrier_byte <= offered.data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern changes after a random stretch; one long hold-off
  initial begin : receiver
    int unsigned rx_style;
    int unsigned style_left;
    int unsigned hold_left;
    out_ready  = 1'b0;
    style_left = 0;
    hold_left  = 0;
    rx_style   = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style   = $urandom_range(0, 3);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (rx_style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (style_left % 3 == 0);
        endcase
      end
    end
  end

  task automatic settle();
    while (carrier_q.size() != 0 || in_valid || pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lsbse_pkg::REG_MODE:      reg_mode      = val[1:0];
      lsbse_pkg::REG_ENCRYPTED: reg_encrypted = val[0];
      lsbse_pkg::REG_CAPACITY:  reg_capacity  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] m, input logic enc, input logic [31:0] cap);
    settle();
    write_reg(lsbse_pkg::REG_MODE, {30'h0, m});
    write_reg(lsbse_pkg::REG_ENCRYPTED, {31'h0, enc});
    write_reg(lsbse_pkg::REG_CAPACITY, cap);
  endtask

  // carrier byte with random upper bits hiding v in the current scheme
  function automatic stim_item_t carrier(input logic [3:0] v, input logic [3:0] flags);
    stim_item_t it;
    it      = '0;
    it.data = 8'($urandom_range(0, 255));
    if (reg_mode == lsbse_pkg::MODE_LSB4) begin
      it.data[3:0] = v;
    end else if (reg_mode == lsbse_pkg::MODE_LSBI) begin
      it.data[0] = v[0] ^ flags[it.data[2:1]];
    end else begin
      it.data[0] = v[0];
    end
    return it;
  endfunction

  task automatic hide_byte(input logic [7:0] value, input logic [3:0] flags);
    if (reg_mode == lsbse_pkg::MODE_LSB4) begin
      draft.push_back(carrier(value[7:4], flags));
      draft.push_back(carrier(value[3:0], flags));
    end else begin
      for (int i = 7; i >= 0; i--) draft.push_back(carrier({3'b000, value[i]}, flags));
    end
  endtask

  // one hidden message; sometimes cut short, sometimes followed by stray bytes
  task automatic queue_message();
    logic [31:0] size;
    logic [3:0]  flags;
    logic [34:0] need;
    stim_item_t  it;
    int unsigned mult;
    int unsigned body_n;
    int unsigned ext_n;
    int unsigned keep;
    bit          err;
    draft.delete();
    mult  = (reg_mode == lsbse_pkg::MODE_LSB4) ? 2 : 8;
    flags = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: size = $urandom_range(0, 4);
      6: size = $urandom_range(5, 12);
      7: size = reg_capacity / mult + $urandom_range(0, 1);  // capacity edge
      8: size = $urandom;
      default: size = 32'h0;
    endcase
    need = {3'b000, size} * mult;
    err  = need > {3'b000, reg_capacity};
    if (reg_mode == lsbse_pkg::MODE_LSBI) begin
      for (int i = 0; i < 4; i++) begin
        it = carrier(4'h0, flags);
        it.data[0] = flags[i];
        draft.push_back(it);
      end
    end
    if (reg_mode == lsbse_pkg::MODE_LSB4) begin
      for (int i = 7; i >= 0; i--) draft.push_back(carrier(size[i*4 +: 4], flags));
    end else begin
      for (int i = 31; i >= 0; i--) draft.push_back(carrier({3'b000, size[i]}, flags));
    end
    if (!err) begin
      // huge bodies are only started, the next restart abandons them
      body_n = (size > 16) ? $urandom_range(1, 3) : size;
      for (int i = 0; i < body_n; i++) hide_byte(8'($urandom_range(0, 255)), flags);
      if (size <= 16 && !reg_encrypted) begin
        ext_n = $urandom_range(0, 4);
        for (int i = 0; i < ext_n; i++) hide_byte(8'($urandom_range(1, 255)), flags);
        hide_byte(8'h00, flags);
      end
    end
    keep = draft.size();
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, draft.size());
    end
    draft[0].start = 1'b1;
    for (int i = 0; i < keep; i++) carrier_q.push_back(draft[i]);
    msg_items += keep;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        it      = '0;
        it.data = 8'($urandom_range(0, 255));
        carrier_q.push_back(it);
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] m, input logic enc, input logic [31:0] cap,
                           input bit long_hold);
    configure(m, enc, cap);
    if (long_hold) begin
      hold_req = 1'b1;
    end
    msg_items = 0;
    while (msg_items < PHASE_ITEMS) queue_message();
  endtask

  initial begin : main
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = lsbse_pkg::REG_MODE;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(lsbse_pkg::MODE_LSB4, 1'b0, 32'h0);
    foreach (DIRECTED[i]) carrier_q.push_back(DIRECTED[i]);

    run_phase(lsbse_pkg::MODE_LSB1, 1'b0, 32'hFFFF_FFFF, 1'b0);
    run_phase(lsbse_pkg::MODE_LSB4, 1'b0, 32'd40, 1'b1);
    run_phase(lsbse_pkg::MODE_LSBI, 1'b1, 32'd48, 1'b0);
    run_phase(lsbse_pkg::MODE_RSVD, 1'b0, 32'd100, 1'b0);  // parses as one-bit
    run_phase(lsbse_pkg::MODE_LSBI, 1'b0, 32'hFFFF_FFFF, 1'b0);
    run_phase(lsbse_pkg::MODE_LSB4, 1'b1, 32'h0, 1'b0);
    run_phase(lsbse_pkg::MODE_LSB1, 1'b1, 32'd24, 1'b0);

    settle();
    if (pending_bytes.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_bytes.size()));
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
